// ----- rtl/atfb_pkg.sv -----
package atfb_pkg;

   // payload capacity of one frame
   localparam int unsigned PAYLOAD_BYTES = 32;
   localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam logic [CNT_W-1:0] PAYLOAD_CNT = CNT_W'(PAYLOAD_BYTES);

   // header layout
   localparam int unsigned HDR_BYTES = 22;
   localparam int unsigned SEQ_W = $clog2(HDR_BYTES);
   localparam logic [SEQ_W-1:0] HDR_LAST_SEQ = SEQ_W'(HDR_BYTES - 1);
   localparam logic [SEQ_W-1:0] HDR_SUM_FIRST = SEQ_W'(3);

   // configuration port
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIM_BYTE    = 3'd0,
      CSR_LENGTH_WORD   = 3'd1,
      CSR_FRAME_TYPE    = 3'd2,
      CSR_RESERVED_WORD = 3'd3,
      CSR_HOP_RADIUS    = 3'd4,
      CSR_TX_OPTIONS    = 3'd5
   } csr_index_type;

   localparam logic [7:0]  RST_DELIM_BYTE    = 8'h7E;
   localparam logic [15:0] RST_LENGTH_WORD   = 16'd51;
   localparam logic [7:0]  RST_FRAME_TYPE    = 8'h10;
   localparam logic [15:0] RST_RESERVED_WORD = 16'hFFFE;
   localparam logic [7:0]  RST_HOP_RADIUS    = 8'h00;
   localparam logic [7:0]  RST_TX_OPTIONS    = 8'h00;

   typedef struct packed {
      logic [7:0]  delim_byte;
      logic [15:0] length_word;
      logic [7:0]  frame_type;
      logic [15:0] reserved_word;
      logic [7:0]  hop_radius;
      logic [7:0]  tx_options;
   } cfg_type;

   // per-message header fields sampled with the first payload beat
   typedef struct packed {
      logic [7:0]  frame_id;
      logic [63:0] dest_addr;
      logic [31:0] fragment_number;
      logic [7:0]  data_type;
   } hdr_item_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       summed;
   } hdr_out_type;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_DATA   = 4'b0010,
      PH_PAD    = 4'b0100,
      PH_CHECK  = 4'b1000
   } phase_type;

endpackage

// ----- rtl/atfb_hdr_mux.sv -----
module atfb_hdr_mux (
   input  atfb_pkg::cfg_type                 cfg,
   input  atfb_pkg::hdr_item_type            item,
   input  logic [atfb_pkg::SEQ_W-1:0]        seq,
   output atfb_pkg::hdr_out_type             hdr
);

   logic [7:0] byte_sel;

   always_comb begin
      unique case (seq)
         5'd0:    byte_sel = cfg.delim_byte;
         5'd1:    byte_sel = cfg.length_word[15:8];
         5'd2:    byte_sel = cfg.length_word[7:0];
         5'd3:    byte_sel = cfg.frame_type;
         5'd4:    byte_sel = item.frame_id;
         5'd5:    byte_sel = item.dest_addr[63:56];
         5'd6:    byte_sel = item.dest_addr[55:48];
         5'd7:    byte_sel = item.dest_addr[47:40];
         5'd8:    byte_sel = item.dest_addr[39:32];
         5'd9:    byte_sel = item.dest_addr[31:24];
         5'd10:   byte_sel = item.dest_addr[23:16];
         5'd11:   byte_sel = item.dest_addr[15:8];
         5'd12:   byte_sel = item.dest_addr[7:0];
         5'd13:   byte_sel = cfg.reserved_word[15:8];
         5'd14:   byte_sel = cfg.reserved_word[7:0];
         5'd15:   byte_sel = cfg.hop_radius;
         5'd16:   byte_sel = cfg.tx_options;
         5'd17:   byte_sel = item.fragment_number[31:24];
         5'd18:   byte_sel = item.fragment_number[23:16];
         5'd19:   byte_sel = item.fragment_number[15:8];
         5'd20:   byte_sel = item.fragment_number[7:0];
         5'd21:   byte_sel = item.data_type;
         default: byte_sel = 8'h00;
      endcase
   end

   // delimiter and length stay out of the checksum
   assign hdr.frame_byte = byte_sel;
   assign hdr.summed     = (seq >= atfb_pkg::HDR_SUM_FIRST);

endmodule

// ----- rtl/api_transmit_frame_builder_core.sv -----
// path: req beat -> input beat register -> output register -> rsp
// throughput: one frame byte per cycle on rsp while rsp_ready holds; mid-message payload
//   beats go 1 per cycle too, a first beat holds req for 22 header bytes, a last for
//   zero padding to PAYLOAD_BYTES and checksum, paced by the single byte output register
// reset: synchronous, active high; clears control state and loads the register defaults
module api_transmit_frame_builder_core (
   input  logic        clock,
   input  logic        reset,
   // payload input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic [63:0] req_dest_addr,
   input  logic [7:0]  req_frame_id,
   input  logic [31:0] req_fragment_number,
   input  logic [7:0]  req_data_type,
   // frame byte output channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_end,
   output logic        rsp_overflow,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [atfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [atfb_pkg::CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   atfb_pkg::cfg_type cfg_ff, cfg_in;

   // input beat register
   logic                   item_valid_ff, item_valid_in;
   logic [7:0]             item_data_ff, item_data_in;
   logic                   item_last_ff, item_last_in;
   atfb_pkg::hdr_item_type item_hdr_ff, item_hdr_in;

   // sequencer state
   atfb_pkg::phase_type            phase_ff, phase_in;
   logic [atfb_pkg::SEQ_W-1:0]     seq_ff, seq_in;
   logic                           in_message_ff, in_message_in;
   logic [atfb_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [7:0]                     sum_ff, sum_in;
   logic                           overflow_ff, overflow_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_ovf_ff, rsp_ovf_in;

   atfb_pkg::hdr_out_type hdr;

   logic       out_free;
   logic       room;       // payload byte still fits
   logic       emit;       // this step produces a frame byte
   logic [7:0] emit_byte;
   logic       emit_end;
   logic       step;       // sequencer advances this cycle
   logic       item_done;  // current beat fully handled
   logic       req_take;
   logic       csr_take;

   atfb_hdr_mux u_hdr_mux (
      .cfg  (cfg_ff),
      .item (item_hdr_ff),
      .seq  (seq_ff),
      .hdr  (hdr)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign room     = (count_ff < atfb_pkg::PAYLOAD_CNT);

   // byte selection for the current phase
   always_comb begin
      emit      = 1'b0;
      emit_byte = 8'h00;
      emit_end  = 1'b0;
      unique case (phase_ff)
         atfb_pkg::PH_HEADER: begin
            emit      = 1'b1;
            emit_byte = hdr.frame_byte;
         end
         atfb_pkg::PH_DATA: begin
            // a beat beyond capacity emits nothing, the sequencer flags it
            emit      = room;
            emit_byte = item_data_ff;
         end
         atfb_pkg::PH_PAD: begin
            emit      = 1'b1;
            emit_byte = 8'h00;
         end
         atfb_pkg::PH_CHECK: begin
            emit      = 1'b1;
            emit_byte = ~sum_ff;
            emit_end  = 1'b1;
         end
         default: begin
            emit      = 1'b0;
            emit_byte = 8'h00;
         end
      endcase
   end

   assign step = item_valid_ff && (out_free || !emit);
   assign item_done = step && ((phase_ff == atfb_pkg::PH_DATA && !item_last_ff) ||
                               (phase_ff == atfb_pkg::PH_CHECK));

   // next beat may enter while the current one retires
   assign req_ready = !item_valid_ff || item_done;
   assign req_take  = req_valid && req_ready;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         unique case (csr_index)
            atfb_pkg::CSR_DELIM_BYTE:    cfg_in.delim_byte    = csr_data[7:0];
            atfb_pkg::CSR_LENGTH_WORD:   cfg_in.length_word   = csr_data;
            atfb_pkg::CSR_FRAME_TYPE:    cfg_in.frame_type    = csr_data[7:0];
            atfb_pkg::CSR_RESERVED_WORD: cfg_in.reserved_word = csr_data;
            atfb_pkg::CSR_HOP_RADIUS:    cfg_in.hop_radius    = csr_data[7:0];
            atfb_pkg::CSR_TX_OPTIONS:    cfg_in.tx_options    = csr_data[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      phase_in      = phase_ff;
      seq_in        = seq_ff;
      in_message_in = in_message_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      overflow_in   = overflow_ff;
      item_valid_in = item_valid_ff;
      item_data_in  = item_data_ff;
      item_last_in  = item_last_ff;
      item_hdr_in   = item_hdr_ff;

      if (step) begin
         unique case (phase_ff)
            atfb_pkg::PH_HEADER: begin
               if (hdr.summed) begin
                  sum_in = sum_ff + hdr.frame_byte;
               end
               if (seq_ff == atfb_pkg::HDR_LAST_SEQ) begin
                  phase_in = atfb_pkg::PH_DATA;
               end else begin
                  seq_in = seq_ff + atfb_pkg::SEQ_W'(1);
               end
            end
            atfb_pkg::PH_DATA: begin
               if (room) begin
                  sum_in   = sum_ff + item_data_ff;
                  count_in = count_ff + atfb_pkg::CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (item_last_ff) begin
                  // pad only while the payload is short
                  if (room && (count_ff + atfb_pkg::CNT_W'(1) == atfb_pkg::PAYLOAD_CNT)) begin
                     phase_in = atfb_pkg::PH_CHECK;
                  end else if (room) begin
                     phase_in = atfb_pkg::PH_PAD;
                  end else begin
                     phase_in = atfb_pkg::PH_CHECK;
                  end
               end else begin
                  item_valid_in = 1'b0;
               end
            end
            atfb_pkg::PH_PAD: begin
               count_in = count_ff + atfb_pkg::CNT_W'(1);
               if (count_ff + atfb_pkg::CNT_W'(1) == atfb_pkg::PAYLOAD_CNT) begin
                  phase_in = atfb_pkg::PH_CHECK;
               end
            end
            atfb_pkg::PH_CHECK: begin
               // frame closed, back to awaiting a first beat
               in_message_in = 1'b0;
               count_in      = '0;
               sum_in        = '0;
               overflow_in   = 1'b0;
               item_valid_in = 1'b0;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      if (req_take) begin
         item_valid_in = 1'b1;
         item_data_in  = req_data_byte;
         item_last_in  = req_last;
         item_hdr_in.frame_id        = req_frame_id;
         item_hdr_in.dest_addr       = req_dest_addr;
         item_hdr_in.fragment_number = req_fragment_number;
         item_hdr_in.data_type       = req_data_type;
         seq_in = '0;
         // first beat of a message opens with the header burst
         phase_in = in_message_in ? atfb_pkg::PH_DATA : atfb_pkg::PH_HEADER;
         in_message_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_end_in   = emit_end;
         rsp_ovf_in   = overflow_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_byte    <= atfb_pkg::RST_DELIM_BYTE;
         cfg_ff.length_word   <= atfb_pkg::RST_LENGTH_WORD;
         cfg_ff.frame_type    <= atfb_pkg::RST_FRAME_TYPE;
         cfg_ff.reserved_word <= atfb_pkg::RST_RESERVED_WORD;
         cfg_ff.hop_radius    <= atfb_pkg::RST_HOP_RADIUS;
         cfg_ff.tx_options    <= atfb_pkg::RST_TX_OPTIONS;
         item_valid_ff <= 1'b0;
         phase_ff      <= atfb_pkg::PH_HEADER;
         seq_ff        <= '0;
         in_message_ff <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         seq_ff        <= seq_in;
         in_message_ff <= in_message_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_data_ff <= item_data_in;
      item_last_ff <= item_last_in;
      item_hdr_ff  <= item_hdr_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_end  = rsp_end_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // payload count never runs past capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= atfb_pkg::PAYLOAD_CNT)
      else $error("payload count beyond capacity");

   // a header burst always starts from a clean message state
   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && phase_ff == atfb_pkg::PH_HEADER)
         |-> (count_ff == '0 && !overflow_ff))
      else $error("header with stale message state");

   // a held beat is only released as it retires
   a_ready_retire: assert property (@(posedge clock) disable iff (reset)
      (req_ready && item_valid_ff) |-> item_done)
      else $error("input taken over a busy beat");

   // a checksum beat ends the message
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (step && emit && emit_end && !req_take) |=> !in_message_ff)
      else $error("message still open after checksum");

endmodule

// ----- sim/api_transmit_frame_builder_core_tb.sv -----
module api_transmit_frame_builder_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // index codes with no register behind them, the block must ignore these writes
   localparam logic [atfb_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [atfb_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   // cycles to let pass after the last frame byte, covers dropped beats still in flight
   localparam int SETTLE_CYCLES = 40;

   // one payload beat as offered on req
   typedef struct packed {
      logic [7:0]             data_byte;
      logic                   last;
      atfb_pkg::hdr_item_type hdr;
   } pay_beat_type;

   // one frame byte as seen on rsp
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic       overflow;
   } frame_beat_type;

   // dut ports, every input driven to a known value from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last = 1'b0;
   logic [63:0] req_dest_addr = '0;
   logic [7:0]  req_frame_id = '0;
   logic [31:0] req_fragment_number = '0;
   logic [7:0]  req_data_type = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_frame_end;
   logic        rsp_overflow;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [atfb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [atfb_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // beats waiting for the driver, and frame bytes the monitor still has to see
   pay_beat_type   beats_waiting[$];
   frame_beat_type frame_bytes_due[$];
   pay_beat_type   req_beat;

   // shadow of the register file and of the framing state
   atfb_pkg::cfg_type shadow_cfg;
   logic        msg_open;
   int unsigned payload_count;
   logic [7:0]  check_sum;
   logic        drop_seen;

   // idling controls, changed per phase
   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        quiet_tail = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;

   int unsigned fail_count = 0;

   api_transmit_frame_builder_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_last            (req_last),
      .req_dest_addr       (req_dest_addr),
      .req_frame_id        (req_frame_id),
      .req_fragment_number (req_fragment_number),
      .req_data_type       (req_data_type),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_overflow        (rsp_overflow),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("api_transmit_frame_builder_core_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // frame prediction
   // ---------------------------------------------------------------------------------

   // queue one frame byte, overflow flag reflects the message so far
   function automatic void emit_byte(input logic [7:0] b, input logic is_end);
      frame_beat_type fb;
      fb.frame_byte = b;
      fb.frame_end  = is_end;
      fb.overflow   = drop_seen;
      frame_bytes_due.push_back(fb);
   endfunction

   // bytes from frame type onward also feed the checksum
   function automatic void emit_summed(input logic [7:0] b);
      check_sum = check_sum + b;
      emit_byte(b, 1'b0);
   endfunction

   // multi-byte fields go out msb first
   function automatic void emit_word(input logic [63:0] w, input int unsigned nbytes);
      for (int i = nbytes; i > 0; i--) begin
         emit_summed(w[(i-1)*8 +: 8]);
      end
   endfunction

   // expected frame bytes caused by one accepted payload beat
   function automatic void predict_frame_bytes(input pay_beat_type b);
      if (!msg_open) begin
         // first beat of a message: whole header ahead of the payload byte
         msg_open      = 1'b1;
         payload_count = 0;
         check_sum     = '0;
         drop_seen     = 1'b0;
         emit_byte(shadow_cfg.delim_byte, 1'b0);
         emit_byte(shadow_cfg.length_word[15:8], 1'b0);
         emit_byte(shadow_cfg.length_word[7:0], 1'b0);
         emit_summed(shadow_cfg.frame_type);
         emit_summed(b.hdr.frame_id);
         emit_word(b.hdr.dest_addr, 8);
         emit_word({48'd0, shadow_cfg.reserved_word}, 2);
         emit_summed(shadow_cfg.hop_radius);
         emit_summed(shadow_cfg.tx_options);
         emit_word({32'd0, b.hdr.fragment_number}, 4);
         emit_summed(b.hdr.data_type);
      end
      if (payload_count < atfb_pkg::PAYLOAD_BYTES) begin
         emit_summed(b.data_byte);
         payload_count++;
      end else begin
         // past capacity: beat is dropped and flagged
         drop_seen = 1'b1;
      end
      if (b.last) begin
         // zero padding is not summed
         while (payload_count < atfb_pkg::PAYLOAD_BYTES) begin
            emit_byte(8'h00, 1'b0);
            payload_count++;
         end
         emit_byte(8'hFF - check_sum, 1'b1);
         msg_open      = 1'b0;
         payload_count = 0;
         check_sum     = '0;
         drop_seen     = 1'b0;
      end
   endfunction

   function automatic void shadow_csr(input logic [atfb_pkg::CSR_IDX_W-1:0] idx,
                                      input logic [atfb_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         atfb_pkg::CSR_DELIM_BYTE:    shadow_cfg.delim_byte    = val[7:0];
         atfb_pkg::CSR_LENGTH_WORD:   shadow_cfg.length_word   = val;
         atfb_pkg::CSR_FRAME_TYPE:    shadow_cfg.frame_type    = val[7:0];
         atfb_pkg::CSR_RESERVED_WORD: shadow_cfg.reserved_word = val;
         atfb_pkg::CSR_HOP_RADIUS:    shadow_cfg.hop_radius    = val[7:0];
         atfb_pkg::CSR_TX_OPTIONS:    shadow_cfg.tx_options    = val[7:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // req driver: holds a beat until taken, random gaps between beats
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_frame_bytes(req_beat);
         end
         if (req_valid && !req_ready) begin
            // beat still pending, payload stays as is
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (beats_waiting.size() > 0) begin
            if (!quiet_tail && $urandom_range(99) < req_gap_pct) begin
               req_gap = $urandom_range(18, 1) - 1;
               req_valid <= 1'b0;
            end else begin
               req_beat = beats_waiting.pop_front();
               req_valid           <= 1'b1;
               req_data_byte       <= req_beat.data_byte;
               req_last            <= req_beat.last;
               req_dest_addr       <= req_beat.hdr.dest_addr;
               req_frame_id        <= req_beat.hdr.frame_id;
               req_fragment_number <= req_beat.hdr.fragment_number;
               req_data_type       <= req_beat.hdr.data_type;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // rsp monitor: checks each frame byte against the oldest expected one
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected frame byte %02h end %0b overflow %0b",
                   rsp_frame_byte, rsp_frame_end, rsp_overflow);
            fail_count++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected %02h actual %02h",
                      want.frame_byte, rsp_frame_byte);
               fail_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b actual %0b", want.frame_end, rsp_frame_end);
               fail_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b actual %0b", want.overflow, rsp_overflow);
               fail_count++;
            end
         end
      end
      // receiver back-pressure in bursts
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(99) < rsp_stall_pct) begin
         rsp_stall = $urandom_range(18, 1) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------

   // random value biased toward all zeros and all ones
   function automatic logic [63:0] pick64();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         0: v = '0;
         1: v = '1;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick32();
      logic [63:0] v;
      v = pick64();
      return v[31:0];
   endfunction

   function automatic logic [15:0] pick16();
      logic [63:0] v;
      v = pick64();
      return v[15:0];
   endfunction

   function automatic logic [7:0] pick8();
      logic [63:0] v;
      v = pick64();
      return v[7:0];
   endfunction

   function automatic void add_beat(input logic [7:0] data, input logic last,
                                    input logic [63:0] fill);
      pay_beat_type b;
      b.data_byte           = data;
      b.last                = last;
      b.hdr.dest_addr       = fill;
      b.hdr.frame_id        = fill[7:0];
      b.hdr.fragment_number = fill[31:0];
      b.hdr.data_type       = fill[7:0];
      beats_waiting.push_back(b);
   endfunction

   // message of random content, header fields vary on every beat
   function automatic void add_message(input int unsigned len);
      pay_beat_type b;
      for (int unsigned i = 1; i <= len; i++) begin
         b.data_byte           = pick8();
         b.last                = (i == len);
         b.hdr.dest_addr       = pick64();
         b.hdr.frame_id        = pick8();
         b.hdr.fragment_number = pick32();
         b.hdr.data_type       = pick8();
         beats_waiting.push_back(b);
      end
   endfunction

   task automatic csr_write(input logic [atfb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [atfb_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      shadow_csr(idx, val);
      csr_valid <= 1'b0;
   endtask

   // write every register with the same value, stray upper bits included
   task automatic csr_write_all(input logic [atfb_pkg::CSR_DATA_W-1:0] val);
      csr_write(atfb_pkg::CSR_DELIM_BYTE, val);
      csr_write(atfb_pkg::CSR_LENGTH_WORD, val);
      csr_write(atfb_pkg::CSR_FRAME_TYPE, val);
      csr_write(atfb_pkg::CSR_RESERVED_WORD, val);
      csr_write(atfb_pkg::CSR_HOP_RADIUS, val);
      csr_write(atfb_pkg::CSR_TX_OPTIONS, val);
   endtask

   task automatic csr_write_random();
      csr_write(atfb_pkg::CSR_DELIM_BYTE, pick16());
      csr_write(atfb_pkg::CSR_LENGTH_WORD, pick16());
      csr_write(atfb_pkg::CSR_FRAME_TYPE, pick16());
      csr_write(atfb_pkg::CSR_RESERVED_WORD, pick16());
      csr_write(atfb_pkg::CSR_HOP_RADIUS, pick16());
      csr_write(atfb_pkg::CSR_TX_OPTIONS, pick16());
      if ($urandom_range(1)) begin
         csr_write($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, pick16());
      end
   endtask

   // block is idle once all beats are taken and every frame byte is out
   task automatic drain();
      do @(negedge clock);
      while (beats_waiting.size() != 0 || req_valid || frame_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // messages of random length until a beat budget is used up
   task automatic add_random_messages(input int unsigned budget);
      int unsigned len;
      int unsigned used;
      used = 0;
      while (used < budget) begin
         // mostly short messages, some around capacity to hit padding-free and overflow
         len = ($urandom_range(99) < 75) ? $urandom_range(6, 1) : $urandom_range(36, 29);
         add_message(len);
         used += len;
      end
   endtask

   initial begin
      shadow_cfg.delim_byte    = atfb_pkg::RST_DELIM_BYTE;
      shadow_cfg.length_word   = atfb_pkg::RST_LENGTH_WORD;
      shadow_cfg.frame_type    = atfb_pkg::RST_FRAME_TYPE;
      shadow_cfg.reserved_word = atfb_pkg::RST_RESERVED_WORD;
      shadow_cfg.hop_radius    = atfb_pkg::RST_HOP_RADIUS;
      shadow_cfg.tx_options    = atfb_pkg::RST_TX_OPTIONS;
      msg_open      = 1'b0;
      payload_count = 0;
      check_sum     = '0;
      drop_seen     = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed, register defaults, no idling
      add_beat(8'h00, 1'b1, 64'd0);
      add_beat(8'hFF, 1'b1, '1);
      // later beats carry other header fields, they must not leak into the frame
      add_beat(8'h5A, 1'b0, 64'h0123_4567_89AB_CDEF);
      add_beat(8'hA5, 1'b0, '1);
      add_beat(8'h80, 1'b1, 64'd0);
      drain();

      // all registers at their maximum, stray bits on the narrow ones, dead indexes
      csr_write_all('1);
      csr_write(CSR_SPARE_A, 16'h1234);
      csr_write(CSR_SPARE_B, '1);
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      add_beat(8'hFF, 1'b1, '1);
      add_beat(8'h00, 1'b1, 64'd0);
      add_beat(8'h7E, 1'b0, 64'h8000_0000_0000_0001);
      add_beat(8'h01, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE);
      drain();

      // all registers zero
      csr_write_all('0);
      add_beat(8'hFF, 1'b1, '1);
      add_beat(8'h00, 1'b0, 64'd0);
      add_beat(8'hFF, 1'b1, '1);
      drain();

      // capacity edges: exactly full, dropped last beat, dropped beats before the last
      csr_write_random();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      add_message(atfb_pkg::PAYLOAD_BYTES);
      add_message(atfb_pkg::PAYLOAD_BYTES + 1);
      add_message(atfb_pkg::PAYLOAD_BYTES + 3);
      add_message(atfb_pkg::PAYLOAD_BYTES - 1);
      drain();

      // random phases, each under its own register setting and idling mix
      for (int phase = 0; phase < 4; phase++) begin
         csr_write_random();
         case (phase)
            0: begin req_gap_pct = 10; rsp_stall_pct = 40; end
            1: begin req_gap_pct = 40; rsp_stall_pct = 10; end
            2: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
            default: begin req_gap_pct = 25; rsp_stall_pct = 25; end
         endcase
         add_random_messages(20);
         drain();
      end

      // closing stretch at full rate
      csr_write_random();
      quiet_tail = 1'b1;
      add_random_messages(20);
      drain();

      if (frame_bytes_due.size() != 0) begin
         $error("%0d frame bytes never arrived", frame_bytes_due.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("api_transmit_frame_builder_core_tb: PASS");
      end else begin
         $display("api_transmit_frame_builder_core_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/atfb_pkg.sv
rtl/atfb_hdr_mux.sv
rtl/api_transmit_frame_builder_core.sv
sim/api_transmit_frame_builder_core_tb.sv
